// ===== rtl/pnds_pkg.sv =====
// ----------------------------------------------------------------------------
// pnds_pkg
// shared types, character constants and the byte classifier for the
// person name dot and space normalizer
// ----------------------------------------------------------------------------
package pnds_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned RUN_MAX = 3;
  localparam int unsigned RUN_CNT_W = 2;

  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  // class comes from the low seven bits, so the 8'h80 bit is ignored
  localparam logic [BYTE_W-1:0] HIGH_BIT = 8'h80;

  typedef enum logic [2:0] {
    MODE_SKIP    = 3'd0,
    MODE_COPY    = 3'd1,
    MODE_ONE_DOT = 3'd2,
    MODE_TWO_DOT = 3'd3,
    MODE_GAP     = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_END  = 2'd1,
    KIND_WS   = 2'd2,
    KIND_DOT  = 2'd3
  } kind_t;

  // up to three output words caused by one input word, data[0] goes first
  typedef struct packed {
    logic [RUN_CNT_W-1:0]           count;
    logic [RUN_MAX-1:0][BYTE_W-1:0] data;
    logic                           name_end;
  } run_t;

  function automatic kind_t classify(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] low;
    kind_t             k;
    low = b & ~HIGH_BIT;
    priority if (low == CH_NUL) begin
      k = KIND_END;
    end else if ((low >= 8'd9 && low <= 8'd13) || low == CH_SPACE || low == 8'h5F) begin
      k = KIND_WS;
    end else if (low == CH_DOT) begin
      k = KIND_DOT;
    end else begin
      k = KIND_TEXT;
    end
    return k;
  endfunction

endpackage

// ===== rtl/pnds_in_if.sv =====
// ----------------------------------------------------------------------------
// pnds_in_if
// input channel: one name byte per word, valid/ready handshake
// ----------------------------------------------------------------------------
interface pnds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ===== rtl/pnds_out_if.sv =====
// ----------------------------------------------------------------------------
// pnds_out_if
// output channel: one canonical byte per word with run and name end flags
// ----------------------------------------------------------------------------
interface pnds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       name_end;

  modport source (output valid, output out_byte, output run_last, output name_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input name_end,
                output ready);
endinterface

// ===== rtl/pnds_skid.sv =====
// ----------------------------------------------------------------------------
// pnds_skid
// input register with skid slot, upstream ready comes straight from a flop
// ----------------------------------------------------------------------------
module pnds_skid
  import pnds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  input  logic [BYTE_W-1:0] s_byte,
  output logic              s_ready,
  output logic              m_valid,
  output logic [BYTE_W-1:0] m_byte,
  input  logic              m_ready
);

  logic              main_valid;
  logic [BYTE_W-1:0] main_byte;
  logic              skid_valid;
  logic [BYTE_W-1:0] skid_byte;
  logic              take;
  logic              pop;

  assign s_ready = !skid_valid;
  assign m_valid = main_valid;
  assign m_byte  = main_byte;
  assign take    = s_valid && s_ready;
  assign pop     = main_valid && m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= take;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_byte <= skid_valid ? skid_byte : s_byte;
    end
    if (take && main_valid && !pop) begin
      skid_byte <= s_byte;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid slot holds a word while the main register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !pop |=> skid_valid && $stable(skid_byte))
    else $error("skid word lost while main register stalled");
`endif

endmodule

// ===== rtl/pnds_fsm.sv =====
// ----------------------------------------------------------------------------
// pnds_fsm
// scan mode register and the single pass that turns one byte into a run
// ----------------------------------------------------------------------------
module pnds_fsm
  import pnds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              run_free,
  output logic              load,
  output run_t              run
);

  mode_t mode;
  mode_t mode_next;
  kind_t kind;
  logic  fire;

  assign kind = classify(in_byte);
  assign fire = in_valid && run_free;
  assign load = fire && (run.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SKIP;
    end else if (fire) begin
      mode <= mode_next;
    end
  end

  always_comb begin
    mode_next    = mode;
    run.count    = 2'd0;
    run.data     = '0;
    run.name_end = 1'b0;
    if (kind == KIND_END) begin
      // a pending dot is flushed before the terminator
      if (mode == MODE_ONE_DOT || mode == MODE_TWO_DOT) begin
        run.count   = 2'd2;
        run.data[0] = CH_DOT;
        run.data[1] = CH_NUL;
      end else begin
        run.count   = 2'd1;
        run.data[0] = CH_NUL;
      end
      run.name_end = 1'b1;
      mode_next    = MODE_SKIP;
    end else begin
      unique case (mode)
        MODE_COPY: begin
          if (kind == KIND_TEXT) begin
            run.count   = 2'd1;
            run.data[0] = in_byte;
          end else if (kind == KIND_WS) begin
            mode_next = MODE_GAP;
          end else begin
            mode_next = MODE_ONE_DOT;
          end
        end
        MODE_ONE_DOT: begin
          if (kind == KIND_TEXT) begin
            run.count   = 2'd2;
            run.data[0] = CH_SPACE;
            run.data[1] = in_byte;
            mode_next   = MODE_COPY;
          end else if (kind == KIND_WS) begin
            run.count   = 2'd1;
            run.data[0] = CH_DOT;
            mode_next   = MODE_GAP;
          end else begin
            mode_next = MODE_TWO_DOT;
          end
        end
        MODE_TWO_DOT: begin
          if (kind == KIND_TEXT) begin
            run.count   = 2'd3;
            run.data[0] = CH_DOT;
            run.data[1] = CH_SPACE;
            run.data[2] = in_byte;
            mode_next   = MODE_COPY;
          end else if (kind == KIND_WS) begin
            run.count   = 2'd1;
            run.data[0] = CH_DOT;
            mode_next   = MODE_GAP;
          end
        end
        MODE_GAP: begin
          if (kind != KIND_WS) begin
            run.count   = 2'd2;
            run.data[0] = CH_SPACE;
            run.data[1] = in_byte;
            mode_next   = MODE_COPY;
          end
        end
        default: begin
          // skipping leading whitespace; unused codes behave the same
          if (kind != KIND_WS) begin
            run.count   = 2'd1;
            run.data[0] = in_byte;
            mode_next   = MODE_COPY;
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && kind == KIND_END |=> mode == MODE_SKIP)
    else $error("mode not back to skip after end of name");

  a_dot_pending: assert property (@(posedge clk) disable iff (rst)
    fire && kind == KIND_DOT && mode == MODE_COPY |=> mode == MODE_ONE_DOT)
    else $error("dot after text did not open a dot run");
`endif

endmodule

// ===== rtl/pnds_run.sv =====
// ----------------------------------------------------------------------------
// pnds_run
// result register holding one run, shifted out one word per handshake
// ----------------------------------------------------------------------------
module pnds_run
  import pnds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  run_t              run,
  output logic              run_free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              run_last,
  output logic              name_end
);

  logic                           valid;
  logic [RUN_CNT_W-1:0]           count;
  logic [RUN_MAX-1:0][BYTE_W-1:0] data;
  logic                           end_flag;
  logic                           pop;

  assign out_valid = valid;
  assign out_byte  = data[0];
  assign run_last  = (count == 2'd1);
  assign name_end  = end_flag && run_last;
  assign pop       = valid && out_ready;
  assign run_free  = !valid || (pop && run_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      count <= '0;
    end else if (load) begin
      valid <= 1'b1;
      count <= run.count;
    end else if (pop) begin
      valid <= !run_last;
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data     <= run.data;
      end_flag <= run.name_end;
    end else if (pop) begin
      data <= {CH_NUL, data[RUN_MAX-1:1]};
    end
  end

`ifndef ASSERT_OFF
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    valid |-> count != 2'd0)
    else $error("result register valid with empty run");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && run_last && !load |=> !valid)
    else $error("result register not empty after last word of a run");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> run_free)
    else $error("new run loaded over undelivered words");
`endif

endmodule

// ===== rtl/person_name_dot_space_normalizer.sv =====
// path: a taken byte waits in the input register until the scanner loads its run into
//   the result register, from which its first word can then be taken
// throughput: one input byte per cycle while each byte yields at most one word and
//   the output is ready; a byte yielding k words holds the result register until all
//   are taken, and the skid slot lets one more byte in while a word waits downstream
// reset: rst, synchronous, active high; empties both buffers, scanner skips whitespace
// ----------------------------------------------------------------------------
// person_name_dot_space_normalizer
// normalizes the spacing and dots of a name string, one byte in, zero to
// three bytes out, with a zero word flagged at the end of each name
// ----------------------------------------------------------------------------
module person_name_dot_space_normalizer
  import pnds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pnds_in_if.sink     in_ch,
  pnds_out_if.source  out_ch
);

  // input register plus skid slot
  logic              fsm_valid;
  logic [BYTE_W-1:0] fsm_byte;
  // run handoff between scanner and result register
  logic              run_free;
  logic              load;
  run_t              run;

  // skid buffer: in_ch.ready is a flop output, no path from out_ch.ready
  pnds_skid u_skid (
    .clk     (clk),
    .rst     (rst),
    .s_valid (in_ch.valid),
    .s_byte  (in_ch.in_byte),
    .s_ready (in_ch.ready),
    .m_valid (fsm_valid),
    .m_byte  (fsm_byte),
    .m_ready (run_free)
  );

  // scanner: classifies the byte and builds its whole run in one pass;
  // the byte is consumed whenever the result register can take a new run,
  // also when the run is empty (whitespace, dots held back)
  pnds_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fsm_valid),
    .in_byte  (fsm_byte),
    .run_free (run_free),
    .load     (load),
    .run      (run)
  );

  // result register: delivers the run word by word; it frees up in the
  // same cycle its last word is taken so runs follow back to back
  pnds_run u_run (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .run       (run),
    .run_free  (run_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .run_last  (out_ch.run_last),
    .name_end  (out_ch.name_end)
  );

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks the name normalizer against a cycle-free software predictor: a
// short table of hand-picked bytes, then random names built from words,
// whitespace runs, dot runs and terminators, with some raw noise bytes.
// both channels idle at random, the result side holds off once for a long
// stretch and the name side pauses once until all results are back
// ----------------------------------------------------------------------------
module tb_top;
  import pnds_pkg::*;

  localparam int unsigned RANDOM_WORDS = 385;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned IDLE_PCT     = 34;
  localparam int unsigned DRAIN_CYCLES = 16;

  // whitespace classes besides the plain space
  localparam logic [6:0] LOW_TAB        = 7'd9;
  localparam logic [6:0] LOW_CR         = 7'd13;
  localparam logic [7:0] CH_UNDERSCORE  = 8'h5F;

  // one output word as it is seen on the result channel
  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       name_end;
  } out_word_t;

  // the zero to three bytes that one input byte causes, ch[0] goes first
  typedef struct packed {
    logic [1:0]      n;
    logic [0:2][7:0] ch;
  } word_run_t;

  // a directed row: typed rows carry their results, the rest go to the predictor
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    word_run_t  run;
  } stim_row_t;

  localparam logic [0:2][7:0] NO_BYTES = '0;

  localparam stim_row_t DIRECTED [25] = '{
    // leading whitespace after reset is dropped, high bit ignored for class
    '{8'h20, 1'b1, '{2'd0, NO_BYTES}},
    '{8'h89, 1'b1, '{2'd0, NO_BYTES}},
    // top text value copied with all eight bits
    '{8'hFF, 1'b1, '{2'd1, {8'hFF, 8'h00, 8'h00}}},
    '{8'h41, 1'b1, '{2'd1, {8'h41, 8'h00, 8'h00}}},
    '{8'h2E, 1'b1, '{2'd0, NO_BYTES}},
    // single dot between words
    '{8'h42, 1'b0, '{2'd0, NO_BYTES}},
    '{8'hAE, 1'b0, '{2'd0, NO_BYTES}},
    '{8'h2E, 1'b0, '{2'd0, NO_BYTES}},
    // third dot in a run is dropped, then double dot between words
    '{8'h2E, 1'b0, '{2'd0, NO_BYTES}},
    '{8'h43, 1'b0, '{2'd0, NO_BYTES}},
    // whitespace run, then a dot opens the next word
    '{CH_UNDERSCORE, 1'b0, '{2'd0, NO_BYTES}},
    '{8'h0D, 1'b0, '{2'd0, NO_BYTES}},
    '{8'h2E, 1'b0, '{2'd0, NO_BYTES}},
    // dot followed by whitespace is kept
    '{8'h2E, 1'b0, '{2'd0, NO_BYTES}},
    '{8'h20, 1'b0, '{2'd0, NO_BYTES}},
    '{8'h44, 1'b0, '{2'd0, NO_BYTES}},
    '{8'h2E, 1'b0, '{2'd0, NO_BYTES}},
    // terminator after one dot keeps the dot
    '{8'h00, 1'b1, '{2'd2, {8'h2E, 8'h00, 8'h00}}},
    // a name made of dots, ended by the high-bit terminator
    '{8'h2E, 1'b0, '{2'd0, NO_BYTES}},
    '{8'h2E, 1'b0, '{2'd0, NO_BYTES}},
    '{8'h2E, 1'b0, '{2'd0, NO_BYTES}},
    '{8'h80, 1'b1, '{2'd2, {8'h2E, 8'h00, 8'h00}}},
    // lowest text value, plain end
    '{8'h8A, 1'b1, '{2'd0, NO_BYTES}},
    '{8'h01, 1'b1, '{2'd1, {8'h01, 8'h00, 8'h00}}},
    '{8'h00, 1'b1, '{2'd1, {8'h00, 8'h00, 8'h00}}}
  };

  logic clk;
  logic rst;

  pnds_in_if  in_ch();
  pnds_out_if out_ch();

  person_name_dot_space_normalizer dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state and the words still owed by the block
  mode_t       name_mode;
  out_word_t   expected_words [$];
  int unsigned mismatches;
  int unsigned cycles;

  // traffic shaping shared by the two sides
  bit          calm;
  int unsigned holds_asked;
  int unsigned holds_served;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ------------------------------------------------------------------ predictor

  // class from the low seven bits only
  function automatic kind_t kind_of(input logic [7:0] b);
    logic [6:0] low;
    kind_t      k;
    low = b[6:0];
    if (low == CH_NUL[6:0]) begin
      k = KIND_END;
    end else if ((low >= LOW_TAB && low <= LOW_CR) || low == CH_SPACE[6:0] ||
                 low == CH_UNDERSCORE[6:0]) begin
      k = KIND_WS;
    end else if (low == CH_DOT[6:0]) begin
      k = KIND_DOT;
    end else begin
      k = KIND_TEXT;
    end
    return k;
  endfunction

  function automatic void add_byte(inout word_run_t r, input logic [7:0] c);
    r.ch[r.n] = c;
    r.n       = r.n + 2'd1;
  endfunction

  // bytes caused by one name byte; advances name_mode
  function automatic word_run_t normalize_byte(input logic [7:0] b);
    word_run_t r;
    kind_t     k;
    r = '0;
    k = kind_of(b);
    if (k == KIND_END) begin
      // a pending dot is flushed before the end mark
      if (name_mode == MODE_ONE_DOT || name_mode == MODE_TWO_DOT) begin
        add_byte(r, CH_DOT);
      end
      add_byte(r, CH_NUL);
      name_mode = MODE_SKIP;
    end else begin
      case (name_mode)
        MODE_COPY: begin
          if (k == KIND_TEXT) begin
            add_byte(r, b);
          end else if (k == KIND_WS) begin
            name_mode = MODE_GAP;
          end else begin
            name_mode = MODE_ONE_DOT;
          end
        end
        MODE_ONE_DOT: begin
          if (k == KIND_TEXT) begin
            // lone dot between words turns into a space
            add_byte(r, CH_SPACE);
            add_byte(r, b);
            name_mode = MODE_COPY;
          end else if (k == KIND_WS) begin
            add_byte(r, CH_DOT);
            name_mode = MODE_GAP;
          end else begin
            name_mode = MODE_TWO_DOT;
          end
        end
        MODE_TWO_DOT: begin
          if (k == KIND_TEXT) begin
            add_byte(r, CH_DOT);
            add_byte(r, CH_SPACE);
            add_byte(r, b);
            name_mode = MODE_COPY;
          end else if (k == KIND_WS) begin
            add_byte(r, CH_DOT);
            name_mode = MODE_GAP;
          end
          // further dots are dropped
        end
        MODE_GAP: begin
          if (k != KIND_WS) begin
            add_byte(r, CH_SPACE);
            add_byte(r, b);
            name_mode = MODE_COPY;
          end
        end
        default: begin
          // skipping leading whitespace
          if (k != KIND_WS) begin
            add_byte(r, b);
            name_mode = MODE_COPY;
          end
        end
      endcase
    end
    return r;
  endfunction

  // ------------------------------------------------------------------ result side

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch @%0d: %s got %02h expected %02h", cycles, what, got, want);
    mismatches++;
  endtask

  // sampled at the rising edge, before the block updates its registers
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_byte, out_ch.run_last, out_ch.name_end};
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, out_byte", got.ch, 8'h00);
      end else begin
        want = expected_words.pop_front();
        if (got.ch !== want.ch) report_mismatch("out_byte", got.ch, want.ch);
        if (got.run_last !== want.run_last) begin
          report_mismatch("run_last", 8'(got.run_last), 8'(want.run_last));
        end
        if (got.name_end !== want.name_end) begin
          report_mismatch("name_end", 8'(got.name_end), 8'(want.name_end));
        end
      end
    end
  end

  // receiver: random ready, a long hold-off on request, none while calm
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    holds_served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               expected_words.size());
      $display("** person_name_dot_space_normalizer: FAILED **");
      $finish;
    end
  end

  // ------------------------------------------------------------------ name side

  int unsigned live_words;

  task automatic push_run(input word_run_t r);
    for (int i = 0; i < int'(r.n); i++) begin
      expected_words.push_back('{r.ch[i], i == int'(r.n) - 1, r.ch[i] == CH_NUL});
    end
  endtask

  // offers one byte until it is taken; the next call or a pause starts at
  // the following falling edge, so valid never covers a taken word twice
  task automatic send_byte(input logic [7:0] b, input logic typed, input word_run_t typed_run);
    word_run_t r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    r = normalize_byte(b);
    push_run(typed ? typed_run : r);
    live_words++;
  endtask

  function automatic logic [7:0] text_byte();
    logic [6:0] low;
    logic       hb;
    do low = 7'($urandom_range(127, 1)); while (kind_of({1'b0, low}) != KIND_TEXT);
    hb = 1'($urandom_range(1));
    return {hb, low};
  endfunction

  function automatic logic [7:0] space_byte();
    logic [6:0] low;
    logic       hb;
    case ($urandom_range(6))
      5:       low = CH_SPACE[6:0];
      6:       low = CH_UNDERSCORE[6:0];
      default: low = LOW_TAB + 7'($urandom_range(4));
    endcase
    hb = 1'($urandom_range(1));
    return {hb, low};
  endfunction

  function automatic logic [7:0] dot_byte();
    logic hb;
    hb = 1'($urandom_range(1));
    return {hb, CH_DOT[6:0]};
  endfunction

  // runs of whitespace or dots, as separators and trailers
  task automatic send_spaces(input int unsigned n);
    for (int i = 0; i < int'(n); i++) send_byte(space_byte(), 1'b0, '0);
  endtask

  task automatic send_dots(input int unsigned n);
    for (int i = 0; i < int'(n); i++) send_byte(dot_byte(), 1'b0, '0);
  endtask

  // mostly well-formed names with random content, some raw noise
  task automatic send_name();
    int unsigned n_words;
    logic        hb;
    if ($urandom_range(6) == 0) begin
      repeat ($urandom_range(10, 3)) send_byte(8'($urandom_range(255)), 1'b0, '0);
    end else begin
      if ($urandom_range(2) == 0) send_spaces($urandom_range(2, 1));
      n_words = $urandom_range(4, 1);
      for (int w = 0; w < int'(n_words); w++) begin
        if (w != 0) begin
          case ($urandom_range(4))
            0, 1: send_spaces($urandom_range(2, 1));
            2:    send_dots(1);
            3:    send_dots($urandom_range(3, 2));
            default: begin
              send_dots($urandom_range(3, 1));
              send_spaces($urandom_range(2, 1));
            end
          endcase
        end
        repeat ($urandom_range(5, 1)) send_byte(text_byte(), 1'b0, '0);
      end
      case ($urandom_range(3))
        1: send_dots($urandom_range(3, 1));
        2: send_spaces($urandom_range(2, 1));
        3: begin
          send_dots(1);
          send_spaces(1);
        end
        default: ;
      endcase
      // both terminator encodings
      hb = 1'($urandom_range(1));
      send_byte({hb, 7'h00}, 1'b0, '0);
    end
  endtask

  // ------------------------------------------------------------------ main

  initial begin
    bit did_hold;
    bit did_pause;
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    name_mode     = MODE_SKIP;
    mismatches    = 0;
    cycles        = 0;
    calm          = 1'b0;
    holds_asked   = 0;
    live_words    = 0;
    did_hold      = 1'b0;
    did_pause     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (DIRECTED[i]) send_byte(DIRECTED[i].b, DIRECTED[i].typed, DIRECTED[i].run);

    // random names
    live_words = 0;
    while (live_words < RANDOM_WORDS) begin
      // result side stops for a while, input keeps coming until it backs up
      if (!did_hold && live_words >= 100) begin
        did_hold = 1'b1;
        holds_asked++;
      end
      // stretch with no idling on either side
      calm = (live_words >= 180 && live_words < 260);
      // input waits until every owed word is back
      if (!did_pause && live_words >= 300) begin
        did_pause = 1'b1;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
      end
      send_name();
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    // drain, then a few quiet cycles to catch stray words
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** person_name_dot_space_normalizer: PASSED **");
    end else begin
      $display("** person_name_dot_space_normalizer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pnds_pkg.sv
rtl/pnds_in_if.sv
rtl/pnds_out_if.sv
rtl/pnds_skid.sv
rtl/pnds_fsm.sv
rtl/pnds_run.sv
rtl/person_name_dot_space_normalizer.sv
test/tb_top.sv
